FILE: design/bme_pkg.sv
// Package of shared types and constants for the bitmap engine.
`timescale 1ns / 1ps
`default_nettype none

package bme_pkg;

  // Size of the bitmap and the widths that follow from it.
  localparam int NBITS       = 256;
  localparam int STORE_BYTES = (NBITS + 7) / 8;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int BCNT_W      = $clog2(STORE_BYTES + 1);
  localparam int CNT_W       = 9;
  localparam int IDX_W       = 9;
  localparam int POS_W       = 8;
  localparam int OP_W        = 4;

  // Constants of the byte population count.
  localparam logic [7:0] POP_M1 = 8'h55;
  localparam logic [7:0] POP_M2 = 8'h33;
  localparam logic [7:0] POP_M4 = 8'h0f;
  localparam logic [7:0] BYTE_ONES = 8'hff;

  // Operation codes of a request; the last code is unused and does nothing.
  typedef enum logic [OP_W-1:0] {
    OP_SET         = 4'd0,
    OP_CLEAR       = 4'd1,
    OP_INVERT      = 4'd2,
    OP_WRITE       = 4'd3,
    OP_READ        = 4'd4,
    OP_SET_ALL     = 4'd5,
    OP_CLEAR_ALL   = 4'd6,
    OP_INVERT_ALL  = 4'd7,
    OP_WRITE_ALL   = 4'd8,
    OP_ALL_ONES    = 4'd9,
    OP_ALL_ZEROS   = 4'd10,
    OP_COUNT_ONES  = 4'd11,
    OP_COUNT_ZEROS = 4'd12,
    OP_FIRST_ONE   = 4'd13,
    OP_FIRST_ZERO  = 4'd14,
    OP_UNUSED      = 4'd15
  } op_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIN
  } state_t;

  // Control handed to the byte unit.
  typedef struct packed {
    op_t        op;
    logic       wv;
    logic [7:0] mask;
  } bme_ctl_t;

  // Results returned by the byte unit.
  typedef struct packed {
    logic [7:0] new_byte;
    logic [3:0] ones;
    logic       hit;
    logic [2:0] hit_pos;
    logic       bit_val;
  } bme_res_t;

endpackage

`default_nettype wire

FILE: design/bme_if.sv
// Channel interfaces of the bitmap engine: request, result and configuration.
`timescale 1ns / 1ps
`default_nettype none

interface bme_in_if import bme_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [IDX_W-1:0] bit_addr;
  logic             write_value;

  modport source (output valid, output op, output bit_addr, output write_value,
                  input ready);
  modport sink (input valid, input op, input bit_addr, input write_value,
                output ready);
endinterface

interface bme_out_if import bme_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             bit_value;
  logic             query_true;
  logic [CNT_W-1:0] count_result;
  logic [POS_W-1:0] position;
  logic             found;
  logic             index_error;

  modport source (output valid, output bit_value, output query_true,
                  output count_result, output position, output found,
                  output index_error, input ready);
  modport sink (input valid, input bit_value, input query_true,
                input count_result, input position, input found,
                input index_error, output ready);
endinterface

interface bme_cfg_if import bme_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/bme_byte_unit.sv
// Shared byte unit: updates one byte of the bitmap, counts its ones and finds its first match.
`timescale 1ns / 1ps
`default_nettype none

module bme_byte_unit import bme_pkg::*; (
  input  wire logic [7:0] byte_in,
  input  bme_ctl_t        ctl,
  output bme_res_t        res
);

  logic [7:0] sel_bits;
  logic [7:0] seek_bits;
  logic [7:0] c1;
  logic [7:0] c2;
  logic [7:0] c4;
  logic [7:0] new_byte;
  logic       hit;
  logic [2:0] hit_pos;

  // New value of the byte under the mask.
  always_comb begin
    case (ctl.op)
      OP_SET, OP_SET_ALL:       new_byte = byte_in | ctl.mask;
      OP_CLEAR, OP_CLEAR_ALL:   new_byte = byte_in & ~ctl.mask;
      OP_INVERT, OP_INVERT_ALL: new_byte = byte_in ^ ctl.mask;
      OP_WRITE, OP_WRITE_ALL: begin
        new_byte = ctl.wv ? (byte_in | ctl.mask) : (byte_in & ~ctl.mask);
      end
      default:                  new_byte = byte_in;
    endcase
  end

  assign sel_bits = byte_in & ctl.mask;

  // Population count of the selected bits by folding pairs, nibbles and halves.
  assign c1 = sel_bits - ((sel_bits >> 1) & POP_M1);
  assign c2 = ((c1 >> 2) & POP_M2) + (c1 & POP_M2);
  assign c4 = ((c2 >> 4) + c2) & POP_M4;

  // Lowest bit that matches the sought value within the mask.
  assign seek_bits = (ctl.op == OP_FIRST_ZERO) ? (~byte_in & ctl.mask) : sel_bits;

  always_comb begin
    hit     = 1'b0;
    hit_pos = 3'd0;
    for (int j = 7; j >= 0; j--) begin
      if (seek_bits[j]) begin
        hit     = 1'b1;
        hit_pos = 3'(j);
      end
    end
  end

  assign res = {new_byte, c4[3:0], hit, hit_pos, |sel_bits};

endmodule

`default_nettype wire

FILE: design/bitmap_engine_core.sv
// Top level of the bitmap engine: sequencer, byte store and result register.
//
// The engine keeps a bitmap of 256 bits in a 32-byte store and answers one
// request at a time. A request on in_ch (op, bit_addr, write_value) is taken
// when valid and ready are both high; ready is high only while the sequencer is
// idle. Exactly one result per request appears on out_ch.
// Single-bit operations read the addressed byte and update it through the shared
// byte unit in ST_EXEC, then load the result in ST_FIN and return to idle. Bulk
// operations and queries walk the bytes covered by active_bits, one byte per
// cycle through the same unit, as the store has a single read port, and then
// load their result in ST_FIN. An out-of-range index, an empty span or an unused
// code goes from idle straight to ST_FIN.
// The result sits in an output register; a new request is taken while it waits,
// and the sequencer holds its next result, not ready, until the receiver has
// taken the first. The cfg_ch port writes active_bits and is always ready; write
// it only when the engine is idle. Reset clears the bitmap through one valid bit
// per byte, sets active_bits to 256 and empties the result register.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_engine_core import bme_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  bme_in_if.sink    in_ch,
  bme_out_if.source out_ch,
  bme_cfg_if.sink   cfg_ch
);

  state_t             state_r, state_nxt;
  op_t                op_r, op_nxt;
  logic               wv_r, wv_nxt;
  logic [2:0]         bit_sel_r, bit_sel_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [ADDR_W-1:0]  last_r, last_nxt;
  logic [CNT_W-1:0]   span_r, span_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               found_r, found_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               bitv_r, bitv_nxt;
  logic               ierr_r, ierr_nxt;
  logic [CNT_W-1:0]   active_bits_r;

  logic               out_valid_r, out_valid_nxt;
  logic               out_bitv_r, out_qt_r, out_found_r, out_ierr_r;
  logic [CNT_W-1:0]   out_cnt_r;
  logic [POS_W-1:0]   out_pos_r;
  logic               out_load;

  logic [7:0]         mem [STORE_BYTES];
  logic [STORE_BYTES-1:0] vld_r;
  logic [ADDR_W-1:0]  rd_addr;
  logic [7:0]         rd_data_r;
  logic               rd_vld_r;
  logic               mem_we;
  logic [7:0]         cur_byte;

  logic [CNT_W-1:0]   span_now;
  logic [CNT_W:0]     nb_sum;
  logic [BCNT_W-1:0]  nbytes;
  logic               single_op;
  logic               is_find;
  logic [BCNT_W-1:0]  full_bytes;
  logic [7:0]         bulk_mask;
  logic [7:0]         unit_mask;
  logic               out_free;

  bme_ctl_t           ctl;
  bme_res_t           res;

  // Span covered by bulk operations and queries, and its length in bytes.
  assign span_now = (active_bits_r > CNT_W'(NBITS)) ? CNT_W'(NBITS) : active_bits_r;
  assign nb_sum   = (CNT_W+1)'(span_now) + (CNT_W+1)'(7);
  assign nbytes   = BCNT_W'(nb_sum >> 3);

  assign single_op = (in_ch.op <= OP_W'(OP_READ));
  assign is_find   = (op_r == OP_FIRST_ONE) || (op_r == OP_FIRST_ZERO);
  assign out_free  = !out_valid_r || out_ch.ready;

  // Mask of the bits of the current byte that lie inside the span.
  assign full_bytes = span_r[CNT_W-1:3];
  always_comb begin
    if (BCNT_W'(addr_r) < full_bytes) begin
      bulk_mask = BYTE_ONES;
    end else if (BCNT_W'(addr_r) == full_bytes) begin
      bulk_mask = ~(BYTE_ONES << span_r[2:0]);
    end else begin
      bulk_mask = 8'd0;
    end
  end

  // Shared byte unit.
  assign cur_byte  = rd_vld_r ? rd_data_r : 8'd0;
  assign unit_mask = (op_r <= OP_READ) ? (8'd1 << bit_sel_r) : bulk_mask;
  assign ctl       = {op_r, wv_r, unit_mask};

  bme_byte_unit u_unit (
    .byte_in (cur_byte),
    .ctl     (ctl),
    .res     (res)
  );

  // Sequencer: next state, accumulators and store control.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    wv_nxt        = wv_r;
    bit_sel_nxt   = bit_sel_r;
    addr_nxt      = addr_r;
    last_nxt      = last_r;
    span_nxt      = span_r;
    cnt_nxt       = cnt_r;
    found_nxt     = found_r;
    pos_nxt       = pos_r;
    bitv_nxt      = bitv_r;
    ierr_nxt      = ierr_r;
    rd_addr       = addr_r + ADDR_W'(1);
    mem_we        = 1'b0;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    case (state_r)
      ST_IDLE: begin
        rd_addr = single_op ? in_ch.bit_addr[ADDR_W+2:3] : '0;
        if (in_ch.valid) begin
          op_nxt      = op_t'(in_ch.op);
          wv_nxt      = in_ch.write_value;
          bit_sel_nxt = in_ch.bit_addr[2:0];
          addr_nxt    = rd_addr;
          last_nxt    = ADDR_W'(nbytes - BCNT_W'(1));
          span_nxt    = span_now;
          cnt_nxt     = '0;
          found_nxt   = 1'b0;
          pos_nxt     = '0;
          bitv_nxt    = 1'b0;
          ierr_nxt    = 1'b0;
          if (single_op) begin
            if (32'(in_ch.bit_addr) >= NBITS) begin
              ierr_nxt  = 1'b1;
              state_nxt = ST_FIN;
            end else begin
              state_nxt = ST_EXEC;
            end
          end else if (in_ch.op == OP_UNUSED || nbytes == '0) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        mem_we   = (op_r <= OP_WRITE) ||
                   (op_r >= OP_SET_ALL && op_r <= OP_WRITE_ALL);
        cnt_nxt  = cnt_r + CNT_W'(res.ones);
        bitv_nxt = (op_r == OP_READ) ? res.bit_val : 1'b0;
        if (is_find && !found_r && res.hit) begin
          found_nxt = 1'b1;
          pos_nxt   = POS_W'({addr_r, res.hit_pos});
        end
        if ((op_r <= OP_READ) || addr_r == last_r) begin
          state_nxt = ST_FIN;
        end else begin
          addr_nxt = addr_r + ADDR_W'(1);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      active_bits_r <= CNT_W'(NBITS);
      vld_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        active_bits_r <= cfg_ch.data;
      end
      if (mem_we) begin
        vld_r[addr_r] <= 1'b1;
      end
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    wv_r      <= wv_nxt;
    bit_sel_r <= bit_sel_nxt;
    addr_r    <= addr_nxt;
    last_r    <= last_nxt;
    span_r    <= span_nxt;
    cnt_r     <= cnt_nxt;
    found_r   <= found_nxt;
    pos_r     <= pos_nxt;
    bitv_r    <= bitv_nxt;
    ierr_r    <= ierr_nxt;
  end

  // Byte store with registered read; an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r] <= res.new_byte;
    end
    rd_data_r <= mem[rd_addr];
    rd_vld_r  <= vld_r[rd_addr];
  end

  // Result register, loaded when the request is finished and the slot is free.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bitv_r  <= bitv_r;
      out_ierr_r  <= ierr_r;
      out_found_r <= is_find && found_r;
      out_pos_r   <= is_find ? pos_r : '0;
      case (op_r)
        OP_ALL_ONES:    out_qt_r <= (cnt_r == span_r);
        OP_ALL_ZEROS:   out_qt_r <= (cnt_r == '0);
        default:        out_qt_r <= 1'b0;
      endcase
      case (op_r)
        OP_COUNT_ONES:  out_cnt_r <= cnt_r;
        OP_COUNT_ZEROS: out_cnt_r <= span_r - cnt_r;
        default:        out_cnt_r <= '0;
      endcase
    end
  end

  // Channel outputs.
  assign in_ch.ready         = (state_r == ST_IDLE);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.bit_value    = out_bitv_r;
  assign out_ch.query_true   = out_qt_r;
  assign out_ch.count_result = out_cnt_r;
  assign out_ch.position     = out_pos_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.index_error  = out_ierr_r;

  // Once a request is taken, the engine is busy on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("engine ready again straight after taking a request");

  // A count never exceeds the active span.
  a_count_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.count_result <= span_now)
    else $error("count result beyond the active span");

  // A found position lies inside the span.
  a_pos_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.found |-> CNT_W'(out_ch.position) < span_now)
    else $error("find position outside the active span");

  // An index error never comes with a find, query or read answer.
  a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.index_error |->
      !out_ch.found && !out_ch.query_true && !out_ch.bit_value)
    else $error("index error reported together with an answer");

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench of the bitmap engine: random requests checked against a bitmap model.
`timescale 1ns / 1ps

module tb;
  import bme_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_REQUESTS = 100;

  // One request to send: either an operation or a write of active_bits.
  typedef struct packed {
    logic             is_cfg;
    logic [CNT_W-1:0] cfg_data;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] bit_addr;
    logic             write_value;
  } request_t;

  // Fields of one result as the engine returns them.
  typedef struct packed {
    logic             bit_value;
    logic             query_true;
    logic [CNT_W-1:0] count_result;
    logic [POS_W-1:0] position;
    logic             found;
    logic             index_error;
  } bitmap_result_t;

  logic clk;
  logic rst_n;

  bme_in_if  in_ch ();
  bme_out_if out_ch ();
  bme_cfg_if cfg_ch ();

  bitmap_engine_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  request_t       pending_requests[$];
  bitmap_result_t expected_results[$];

  // Model of the bitmap and of the active_bits register.
  logic [NBITS-1:0] bitmap_model;
  int unsigned      active_bits_model;

  int issued_count;
  int retired_count;
  int request_total;
  int mismatch_count = 0;
  int cycle_count = 0;
  logic calm_stretch;

  // Neither side idles while these requests go through.
  assign calm_stretch = (issued_count >= 500) && (issued_count < 800);

  // Applies one operation to the bitmap model and returns the result it yields.
  function automatic bitmap_result_t apply_request(logic [OP_W-1:0] op,
                                                   logic [IDX_W-1:0] idx,
                                                   logic wv);
    bitmap_result_t   r;
    int               span;
    int               ones;
    int               i;
    logic [NBITS-1:0] span_mask;
    r = '0;
    span = (active_bits_model > NBITS) ? NBITS : active_bits_model;
    span_mask = (span == 0) ? '0 : ({NBITS{1'b1}} >> (NBITS - span));
    ones = $countones(bitmap_model & span_mask);
    case (op)
      OP_SET, OP_CLEAR, OP_INVERT, OP_WRITE, OP_READ: begin
        if (idx >= NBITS) begin
          r.index_error = 1'b1;
        end else begin
          case (op)
            OP_SET:    bitmap_model[idx] = 1'b1;
            OP_CLEAR:  bitmap_model[idx] = 1'b0;
            OP_INVERT: bitmap_model[idx] = ~bitmap_model[idx];
            OP_WRITE:  bitmap_model[idx] = wv;
            default:   r.bit_value = bitmap_model[idx];
          endcase
        end
      end
      OP_SET_ALL:     bitmap_model = bitmap_model | span_mask;
      OP_CLEAR_ALL:   bitmap_model = bitmap_model & ~span_mask;
      OP_INVERT_ALL:  bitmap_model = bitmap_model ^ span_mask;
      OP_WRITE_ALL:   bitmap_model = wv ? (bitmap_model | span_mask)
                                        : (bitmap_model & ~span_mask);
      OP_ALL_ONES:    r.query_true = (ones == span);
      OP_ALL_ZEROS:   r.query_true = (ones == 0);
      OP_COUNT_ONES:  r.count_result = CNT_W'(ones);
      OP_COUNT_ZEROS: r.count_result = CNT_W'(span - ones);
      OP_FIRST_ONE, OP_FIRST_ZERO: begin
        for (i = 0; i < span; i++) begin
          if (!r.found && (bitmap_model[i] == (op == OP_FIRST_ONE))) begin
            r.found = 1'b1;
            r.position = POS_W'(i);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic add_request(logic [OP_W-1:0] op, int idx, logic wv);
    request_t q;
    q = '0;
    q.op = op;
    q.bit_addr = IDX_W'(idx);
    q.write_value = wv;
    pending_requests.push_back(q);
    request_total++;
  endtask

  task automatic add_config(int value);
    request_t q;
    q = '0;
    q.is_cfg = 1'b1;
    q.cfg_data = CNT_W'(value);
    pending_requests.push_back(q);
  endtask

  // Mostly single-bit work and queries; bulk operations now and then so that
  // the bitmap swings between dense and sparse.
  task automatic add_random_request();
    int pick;
    int idx;
    pick = $urandom_range(0, 99);
    idx = ($urandom_range(0, 99) < 80) ? $urandom_range(0, NBITS - 1)
                                       : $urandom_range(0, 511);
    if (pick < 50) begin
      add_request(OP_W'($urandom_range(OP_SET, OP_READ)), idx, 1'($urandom_range(0, 1)));
    end else if (pick < 85) begin
      add_request(OP_W'($urandom_range(OP_ALL_ONES, OP_FIRST_ZERO)), idx,
                  1'($urandom_range(0, 1)));
    end else if (pick < 97) begin
      add_request(OP_W'($urandom_range(OP_SET_ALL, OP_WRITE_ALL)), idx,
                  1'($urandom_range(0, 1)));
    end else begin
      add_request(OP_UNUSED, idx, 1'($urandom_range(0, 1)));
    end
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Driver: presents requests and register writes from the pending queue and
  // predicts each request as it is accepted.
  always @(posedge clk) begin : drive_requests
    request_t head;
    logic     in_v;
    logic     cfg_v;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.op <= '0;
      in_ch.bit_addr <= '0;
      in_ch.write_value <= 1'b0;
      cfg_ch.valid <= 1'b0;
      cfg_ch.data <= '0;
      issued_count <= 0;
      bitmap_model = '0;
      active_bits_model = 256;
    end else begin
      in_v = in_ch.valid;
      cfg_v = cfg_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(apply_request(in_ch.op, in_ch.bit_addr,
                                                 in_ch.write_value));
        issued_count <= issued_count + 1;
        in_v = 1'b0;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        active_bits_model = 32'(cfg_ch.data);
        cfg_v = 1'b0;
      end
      if (!in_v && !cfg_v && (pending_requests.size() > 0) &&
          (calm_stretch || ($urandom_range(0, 99) >= 20))) begin
        head = pending_requests[0];
        if (!head.is_cfg) begin
          void'(pending_requests.pop_front());
          in_v = 1'b1;
          in_ch.op <= head.op;
          in_ch.bit_addr <= head.bit_addr;
          in_ch.write_value <= head.write_value;
        end else if ((issued_count == retired_count) && !(in_ch.valid && in_ch.ready)) begin
          // The register is only written once every result has been taken.
          void'(pending_requests.pop_front());
          cfg_v = 1'b1;
          cfg_ch.data <= head.cfg_data;
        end
      end
      in_ch.valid <= in_v;
      cfg_ch.valid <= cfg_v;
    end
  end

  // Monitor: takes results with random back-pressure and checks each one
  // against the oldest prediction.
  always @(posedge clk) begin : check_results
    bitmap_result_t got;
    bitmap_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      retired_count <= 0;
    end else begin
      out_ch.ready <= calm_stretch || ($urandom_range(0, 99) >= 20);
      if (out_ch.valid && out_ch.ready) begin
        got.bit_value = out_ch.bit_value;
        got.query_true = out_ch.query_true;
        got.count_result = out_ch.count_result;
        got.position = out_ch.position;
        got.found = out_ch.found;
        got.index_error = out_ch.index_error;
        if (retired_count >= issued_count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("tb: result with no request outstanding at cycle %0d", cycle_count);
        end else begin
          want = expected_results.pop_front();
          retired_count <= retired_count + 1;
          if ((got.bit_value !== want.bit_value) || (got.query_true !== want.query_true) ||
              (got.count_result !== want.count_result) ||
              (got.position !== want.position) ||
              (got.found !== want.found) || (got.index_error !== want.index_error)) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("tb: mismatch on result %0d at cycle %0d", retired_count, cycle_count);
              $display("  expected bit %0b query %0b count %0d pos %0d found %0b err %0b",
                       want.bit_value, want.query_true, want.count_result, want.position,
                       want.found, want.index_error);
              $display("  actual   bit %0b query %0b count %0d pos %0d found %0b err %0b",
                       got.bit_value, got.query_true, got.count_result, got.position,
                       got.found, got.index_error);
            end
          end
        end
      end
    end
  end

  // Watchdog on the length of the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Reset, stimulus and the end of the run.
  initial begin : run_test
    int phase;
    int n;
    int span_values[12];
    rst_n = 1'b0;
    request_total = 0;

    // Directed part on the full span: empty bitmap, both ends, bad indexes.
    add_request(OP_COUNT_ZEROS, 0, 0);
    add_request(OP_ALL_ZEROS, 0, 0);
    add_request(OP_FIRST_ONE, 0, 0);
    add_request(OP_FIRST_ZERO, 0, 0);
    add_request(OP_SET, NBITS - 1, 0);
    add_request(OP_SET, 0, 0);
    add_request(OP_READ, NBITS - 1, 0);
    add_request(OP_COUNT_ONES, 0, 0);
    add_request(OP_CLEAR, 0, 0);
    add_request(OP_FIRST_ONE, 0, 0);
    add_request(OP_INVERT, 7, 0);
    add_request(OP_WRITE, 100, 1);
    add_request(OP_WRITE, 7, 0);
    add_request(OP_READ, NBITS, 0);
    add_request(OP_SET, 511, 1);
    add_request(OP_UNUSED, 511, 1);
    add_request(OP_SET_ALL, 0, 0);
    add_request(OP_ALL_ONES, 0, 0);
    add_request(OP_FIRST_ZERO, 0, 0);
    add_request(OP_INVERT_ALL, 0, 0);
    add_request(OP_WRITE_ALL, 0, 1);
    add_request(OP_WRITE_ALL, 0, 0);
    add_request(OP_CLEAR_ALL, 0, 0);

    // Empty span: bulk operations do nothing and queries give their empty answers.
    add_config(0);
    add_request(OP_SET_ALL, 0, 0);
    add_request(OP_ALL_ONES, 0, 0);
    add_request(OP_ALL_ZEROS, 0, 0);
    add_request(OP_COUNT_ZEROS, 0, 0);
    add_request(OP_FIRST_ZERO, 0, 0);
    add_request(OP_INVERT_ALL, 0, 0);

    // Random phases, each behind a fresh span setting; 511 exceeds the bitmap.
    span_values = '{1, 511, 8, 256, 9, 255, 0, 7, 128, 300, 0, 0};
    span_values[10] = $urandom_range(0, 511);
    span_values[11] = $urandom_range(1, 64);
    for (phase = 0; phase < 12; phase++) begin
      add_config(span_values[phase]);
      for (n = 0; n < PHASE_REQUESTS; n++)
        add_random_request();
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while ((issued_count != request_total) || (retired_count != issued_count));
    repeat (40) @(posedge clk);

    if ((mismatch_count == 0) && (expected_results.size() == 0))
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
